>>> src/scd_pkg.sv
// scd_pkg: shared types, scancode constants and character tables for the
// set-1 scancode decoder. No dependencies.

package scd_pkg;

	// event kinds on the result channel
	localparam logic [1:0] KIND_CHAR      = 2'd0;
	localparam logic [1:0] KIND_BACKSPACE = 2'd1;
	localparam logic [1:0] KIND_ARROW     = 2'd2;
	localparam logic [1:0] KIND_LED       = 2'd3;

	// arrow directions
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// scancodes
	localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
	localparam logic [6:0] SC_LSHIFT     = 7'd42;
	localparam logic [6:0] SC_RSHIFT     = 7'd54;
	localparam logic [6:0] SC_CTRL       = 7'd29;
	localparam logic [6:0] SC_ALT        = 7'd56;
	localparam logic [6:0] SC_CAPS       = 7'd58;
	localparam logic [6:0] SC_UP         = 7'h48;
	localparam logic [6:0] SC_DOWN       = 7'h50;
	localparam logic [6:0] SC_LEFT       = 7'h4B;
	localparam logic [6:0] SC_RIGHT      = 7'h4D;

	localparam logic [6:0] ASCII_BS = 7'd8;
	localparam logic [6:0] ASCII_A  = 7'h61;
	localparam logic [6:0] ASCII_Z  = 7'h7A;
	localparam logic [6:0] CASE_GAP = 7'd32;

	typedef struct packed {
		logic ext;
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} key_flags_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] chr;
		logic [1:0] dir;
		logic [2:0] leds;
		logic       ctrl;
		logic       alt;
	} key_event_t;

	// unshifted map
	function automatic logic [6:0] rom_lower(input logic [6:0] code);
		logic [6:0] c;
		case (code)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;  7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;  7'd9:  c = 7'h38;
			7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;  7'd13: c = 7'h3D;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;
			7'd16: c = 7'h71;  7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;
			7'd20: c = 7'h74;  7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;
			7'd24: c = 7'h6F;  7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
			7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;  7'd47: c = 7'h76;
			7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;  7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;  7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			7'd74: c = 7'h2D;  7'd78: c = 7'h2B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// shifted map
	function automatic logic [6:0] rom_upper(input logic [6:0] code);
		logic [6:0] c;
		case (code)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;  7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;  7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;  7'd13: c = 7'h2B;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;
			7'd16: c = 7'h51;  7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;
			7'd20: c = 7'h54;  7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;
			7'd24: c = 7'h4F;  7'd25: c = 7'h50;  7'd26: c = 7'h7B;  7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
			7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;  7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;  7'd47: c = 7'h56;
			7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;  7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;  7'd53: c = 7'h3F;
			7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

>>> src/scd_decode.sv
// scd_decode: combinational decode of one scancode byte against the current
// modifier flags. Uses scd_pkg for tables, codes and types.

module scd_decode import scd_pkg::*; (
	input  logic [7:0]  scan_byte,
	input  key_flags_t  flags,
	output key_flags_t  flags_next,
	output logic        has_event,
	output key_event_t  evt
);

	logic [6:0] code;
	logic [6:0] rom_chr;
	logic [6:0] chr;

	assign code = scan_byte[6:0];

	always_comb begin
		rom_chr = flags.shift ? rom_upper(code) : rom_lower(code);
		if (flags.caps && (rom_chr inside {[ASCII_A:ASCII_Z]})) begin
			chr = rom_chr - CASE_GAP;
		end else begin
			chr = rom_chr;
		end
	end

	always_comb begin
		flags_next = flags;
		has_event  = 1'b0;
		evt.kind   = KIND_CHAR;
		evt.chr    = '0;
		evt.dir    = DIR_UP;
		evt.leds   = '0;

		if (scan_byte == SC_EXT_PREFIX) begin
			flags_next.ext = 1'b1;
		end else begin
			flags_next.ext = 1'b0;
			if (scan_byte[7]) begin
				// break code
				if (code inside {SC_LSHIFT, SC_RSHIFT}) flags_next.shift = 1'b0;
				if (code == SC_CTRL) flags_next.ctrl = 1'b0;
				if (code == SC_ALT)  flags_next.alt  = 1'b0;
			end else if (code inside {SC_LSHIFT, SC_RSHIFT}) begin
				flags_next.shift = 1'b1;
			end else if (code == SC_CTRL) begin
				flags_next.ctrl = 1'b1;
			end else if (code == SC_ALT) begin
				flags_next.alt = 1'b1;
			end else if (code == SC_CAPS) begin
				flags_next.caps = ~flags.caps;
				has_event = 1'b1;
				evt.kind  = KIND_LED;
				evt.leds  = {~flags.caps, 2'b00};
			end else if (flags.ext) begin
				case (code)
					SC_UP:    begin has_event = 1'b1; evt.kind = KIND_ARROW; evt.dir = DIR_UP;    end
					SC_DOWN:  begin has_event = 1'b1; evt.kind = KIND_ARROW; evt.dir = DIR_DOWN;  end
					SC_LEFT:  begin has_event = 1'b1; evt.kind = KIND_ARROW; evt.dir = DIR_LEFT;  end
					SC_RIGHT: begin has_event = 1'b1; evt.kind = KIND_ARROW; evt.dir = DIR_RIGHT; end
					default:  has_event = 1'b0;
				endcase
			end else if (chr == ASCII_BS) begin
				has_event = 1'b1;
				evt.kind  = KIND_BACKSPACE;
			end else if (chr != 7'd0) begin
				has_event = 1'b1;
				evt.kind  = KIND_CHAR;
				evt.chr   = chr;
			end
		end

		evt.ctrl = flags_next.ctrl;
		evt.alt  = flags_next.alt;
	end

endmodule

>>> src/scd_out_reg.sv
// scd_out_reg: result register between the decoder and the event channel.
// Uses scd_pkg for the event type.

module scd_out_reg import scd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	input  key_event_t load_evt,
	output logic       free,
	input  logic       stall,
	output logic       valid,
	output key_event_t evt
);

	logic       valid_q;
	key_event_t evt_q;

	// slot frees when empty or when its beat leaves this cycle
	assign free  = ~valid_q | ~stall;
	assign valid = valid_q;
	assign evt   = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load_valid) begin
			evt_q <= load_evt;
		end
	end

endmodule

>>> src/scancode_set1_key_decoder.sv
// scancode_set1_key_decoder: top level of the set-1 scancode decoder.
// Uses scd_pkg, scd_decode and scd_out_reg.
// a byte in the input register is decoded combinationally; its event goes to scd_out_reg
// one byte per cycle unless stalled; modifier flags update in the same cycle as the decode
// stalls on the event side back up through the input register to scan_stall
// reset: arst_n clears the modifier, caps and prefix flags and both valid bits

module scancode_set1_key_decoder import scd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// scancode channel
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_byte,
	// event channel
	output logic       event_valid,
	input  logic       event_stall,
	output logic [1:0] event_kind,
	output logic [6:0] char_code,
	output logic [1:0] arrow_dir,
	output logic [2:0] led_mask,
	output logic       ctrl_held,
	output logic       alt_held
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// keyboard flags, live state
	key_flags_t flags_q;
	key_flags_t flags_next;

	logic       dec_has;
	key_event_t dec_evt;
	key_event_t out_evt;
	logic       out_free;
	logic       advance;
	logic       scan_take;

	// the byte in s1 leaves when it makes no event or the result slot is free
	assign advance    = valid_s1 & (~dec_has | out_free);
	assign scan_stall = valid_s1 & ~advance;
	assign scan_take  = scan_valid & ~scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			byte_s1 <= scan_byte;
		end
	end

	// flags commit only when the byte actually moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance) begin
			flags_q <= flags_next;
		end
	end

	scd_decode u_decode (
		.scan_byte  (byte_s1),
		.flags      (flags_q),
		.flags_next (flags_next),
		.has_event  (dec_has),
		.evt        (dec_evt)
	);

	scd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1 & dec_has),
		.load_evt   (dec_evt),
		.free       (out_free),
		.stall      (event_stall),
		.valid      (event_valid),
		.evt        (out_evt)
	);

	assign event_kind = out_evt.kind;
	assign char_code  = out_evt.chr;
	assign arrow_dir  = out_evt.dir;
	assign led_mask   = out_evt.leds;
	assign ctrl_held  = out_evt.ctrl;
	assign alt_held   = out_evt.alt;

	// prefix flag only ever arms from a prefix byte leaving s1
	a_ext_from_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flags_q.ext) |-> $past(valid_s1) && $past(byte_s1) == SC_EXT_PREFIX)
		else $error("extended flag set without prefix byte");

	// every caps toggle lands with its led beat carrying the new state
	a_caps_led: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flags_q.caps) |->
			event_valid && event_kind == KIND_LED && led_mask[2] == flags_q.caps)
		else $error("caps toggled without matching led beat");

	// character beats never carry a null code
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == KIND_CHAR |-> char_code != 7'd0)
		else $error("null character emitted");

	// arrow beats carry no character or led bits
	a_arrow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == KIND_ARROW |-> char_code == 7'd0 && led_mask == 3'd0)
		else $error("arrow beat with stray payload");

endmodule
